// ----- design/yrgb_pkg.sv -----
// Package for the YUYV to RGB pair converter.
// Holds field widths, fixed offsets, clip levels, coefficient defaults and register indexes.
// No dependencies.
package yrgb_pkg;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 12;
    localparam int FRAC_W  = 10;
    localparam int CFG_IDX_W = 3;

    // Offset luma is signed 9 bits; a product of a gain and it needs 22 bits.
    localparam int LUMA_PROD_W   = COEF_W + 1 + PIX_W + 1;
    localparam int CHROMA_PROD_W = COEF_W + 1 + PIX_W;
    localparam int SUM_W         = 24;

    localparam logic signed [PIX_W+1:0] LUMA_OFFSET = 10'sd16;
    localparam logic signed [SUM_W-1:0] CLIP_LEVEL  = SUM_W'(250 << FRAC_W);
    localparam logic [PIX_W-1:0]        CLIP_VALUE  = 8'd255;

    localparam logic [COEF_W-1:0] LUMA_GAIN_RST     = 12'd1192;
    localparam logic [COEF_W-1:0] BLUE_FROM_CB_RST  = 12'd2066;
    localparam logic [COEF_W-1:0] GREEN_FROM_CR_RST = 12'd833;
    localparam logic [COEF_W-1:0] GREEN_FROM_CB_RST = 12'd403;
    localparam logic [COEF_W-1:0] RED_FROM_CR_RST   = 12'd1634;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_GAIN     = 3'd0,
        REG_BLUE_FROM_CB  = 3'd1,
        REG_GREEN_FROM_CR = 3'd2,
        REG_GREEN_FROM_CB = 3'd3,
        REG_RED_FROM_CR   = 3'd4
    } cfg_reg_t;

    // Products of one macropixel, formed ahead of the channel sums.
    typedef struct packed {
        logic signed [LUMA_PROD_W-1:0]   base_first;
        logic signed [LUMA_PROD_W-1:0]   base_second;
        logic signed [CHROMA_PROD_W-1:0] red_cr;
        logic signed [CHROMA_PROD_W-1:0] green_cr;
        logic signed [CHROMA_PROD_W-1:0] green_cb;
        logic signed [CHROMA_PROD_W-1:0] blue_cb;
    } prod_t;

endpackage

// ----- design/yuyv_to_rgb_pair_converter.sv -----
// Top level of the YUYV 4:2:2 to RGB888 pair converter.
// Depends on yrgb_pkg for widths, constants, register indexes and the product struct.
//
// The block takes one YUYV macropixel word per clock and returns one word of two RGB888
// pixels per clock unless stalled by m_tready. An accepted word sits in the input register;
// six parallel multipliers (two 13x9 for luma, four 13x8 for chroma), the channel sums
// and the clamp turn it into the result register. Unstalled, it moves one word per cycle.
// Backpressure from m_tready holds both registers, and s_tready drops only while both hold
// a word and the result is not taken. The five Q2.10 coefficients are written through the
// cfg port, which is always ready; they must only be changed while no word is in flight.
// Writes to indexes 5 to 7 are ignored.
module yuyv_to_rgb_pair_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma_first, chroma_blue, luma_second, chroma_red (8 bits each, lowest first)
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second (8 bits each)
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [yrgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrgb_pkg::COEF_W-1:0]    cfg_data
);

    localparam int PW  = yrgb_pkg::PIX_W;
    localparam int CW  = yrgb_pkg::COEF_W;
    localparam int SW  = yrgb_pkg::SUM_W;
    localparam int LPW = yrgb_pkg::LUMA_PROD_W;
    localparam int CPW = yrgb_pkg::CHROMA_PROD_W;

    logic [CW-1:0] luma_gain_reg, blue_from_cb_reg, green_from_cr_reg;
    logic [CW-1:0] green_from_cb_reg, red_from_cr_reg;

    logic        in_valid_reg, out_valid_reg;
    logic [31:0] in_data_reg;
    yrgb_pkg::prod_t prod;
    logic [47:0] out_data_reg, out_data_next;

    logic out_en, in_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_gain_reg     <= yrgb_pkg::LUMA_GAIN_RST;
            blue_from_cb_reg  <= yrgb_pkg::BLUE_FROM_CB_RST;
            green_from_cr_reg <= yrgb_pkg::GREEN_FROM_CR_RST;
            green_from_cb_reg <= yrgb_pkg::GREEN_FROM_CB_RST;
            red_from_cr_reg   <= yrgb_pkg::RED_FROM_CR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                yrgb_pkg::REG_LUMA_GAIN:     luma_gain_reg     <= cfg_data;
                yrgb_pkg::REG_BLUE_FROM_CB:  blue_from_cb_reg  <= cfg_data;
                yrgb_pkg::REG_GREEN_FROM_CR: green_from_cr_reg <= cfg_data;
                yrgb_pkg::REG_GREEN_FROM_CB: green_from_cb_reg <= cfg_data;
                yrgb_pkg::REG_RED_FROM_CR:   red_from_cr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage moves on when the one after it is empty or moving on too.
    assign out_en   = !out_valid_reg || m_tready;
    assign in_en    = !in_valid_reg || out_en;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_en) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (out_en && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // Products.
    logic signed [PW+1:0] luma_first_off, luma_second_off;
    logic signed [PW-1:0] cb, cr;
    logic signed [CW:0]   g_luma, g_bcb, g_gcr, g_gcb, g_rcr;

    always_comb begin
        luma_first_off  = $signed({2'b00, in_data_reg[7:0]}) - yrgb_pkg::LUMA_OFFSET;
        luma_second_off = $signed({2'b00, in_data_reg[23:16]}) - yrgb_pkg::LUMA_OFFSET;
        // Flipping the top bit of an offset-128 byte gives its signed value.
        cb = $signed({~in_data_reg[15], in_data_reg[14:8]});
        cr = $signed({~in_data_reg[31], in_data_reg[30:24]});
        g_luma = $signed({1'b0, luma_gain_reg});
        g_bcb  = $signed({1'b0, blue_from_cb_reg});
        g_gcr  = $signed({1'b0, green_from_cr_reg});
        g_gcb  = $signed({1'b0, green_from_cb_reg});
        g_rcr  = $signed({1'b0, red_from_cr_reg});
        prod.base_first  = LPW'(g_luma) * LPW'(luma_first_off);
        prod.base_second = LPW'(g_luma) * LPW'(luma_second_off);
        prod.red_cr      = CPW'(g_rcr) * CPW'(cr);
        prod.green_cr    = CPW'(g_gcr) * CPW'(cr);
        prod.green_cb    = CPW'(g_gcb) * CPW'(cb);
        prod.blue_cb     = CPW'(g_bcb) * CPW'(cb);
    end

    function automatic logic [PW-1:0] clamp_channel(input logic signed [SW-1:0] sum);
        logic [PW-1:0] res;
        if (sum < 0) begin
            res = '0;
        end else if (sum > yrgb_pkg::CLIP_LEVEL) begin
            res = yrgb_pkg::CLIP_VALUE;
        end else begin
            res = sum[yrgb_pkg::FRAC_W +: PW];
        end
        return res;
    endfunction

    // Sums and clamp.
    logic signed [SW-1:0] base0, base1, rcr, gcr, gcb, bcb;
    logic signed [SW-1:0] red0, green0, blue0, red1, green1, blue1;

    always_comb begin
        base0 = SW'(prod.base_first);
        base1 = SW'(prod.base_second);
        rcr   = SW'(prod.red_cr);
        gcr   = SW'(prod.green_cr);
        gcb   = SW'(prod.green_cb);
        bcb   = SW'(prod.blue_cb);
        red0   = base0 + rcr;
        green0 = base0 - gcr - gcb;
        blue0  = base0 + bcb;
        red1   = base1 + rcr;
        green1 = base1 - gcr - gcb;
        blue1  = base1 + bcb;
        out_data_next = {clamp_channel(blue1), clamp_channel(green1), clamp_channel(red1),
                         clamp_channel(blue0), clamp_channel(green0), clamp_channel(red0)};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- verif/yuyv_to_rgb_pair_converter_tb.sv -----
// Self-checking testbench for the YUYV to RGB pair converter.
// Predicts every pixel pair from the coefficient registers and compares each result word.
// Depends on yrgb_pkg and yuyv_to_rgb_pair_converter.
module yuyv_to_rgb_pair_converter_tb;

    localparam int PIX_W        = yrgb_pkg::PIX_W;
    localparam int COEF_W       = yrgb_pkg::COEF_W;
    localparam int FRAC_W       = yrgb_pkg::FRAC_W;
    localparam int CFG_IDX_W    = yrgb_pkg::CFG_IDX_W;
    localparam int LUMA_BIAS    = 16;
    localparam int CHROMA_BIAS  = 128;
    localparam int CLIP_SUM     = 250 << FRAC_W;
    localparam int NUM_COEFS    = 5;
    localparam int PIPE_DEPTH   = 2;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 250;
    localparam int TIMEOUT      = 20_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] chroma_red;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_first;
    } yuyv_word_t;

    // Holds the coefficient registers and the pixel pairs still to come out of the block.
    class rgb_pair_scoreboard;
        logic [COEF_W-1:0] luma_gain, blue_from_cb, green_from_cr, green_from_cb, red_from_cr;
        logic [47:0] pairs_due[$];
        int errors;
        int checked;

        function new();
            luma_gain     = yrgb_pkg::LUMA_GAIN_RST;
            blue_from_cb  = yrgb_pkg::BLUE_FROM_CB_RST;
            green_from_cr = yrgb_pkg::GREEN_FROM_CR_RST;
            green_from_cb = yrgb_pkg::GREEN_FROM_CB_RST;
            red_from_cr   = yrgb_pkg::RED_FROM_CR_RST;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
            case (idx)
                yrgb_pkg::REG_LUMA_GAIN:     luma_gain     = value;
                yrgb_pkg::REG_BLUE_FROM_CB:  blue_from_cb  = value;
                yrgb_pkg::REG_GREEN_FROM_CR: green_from_cr = value;
                yrgb_pkg::REG_GREEN_FROM_CB: green_from_cb = value;
                yrgb_pkg::REG_RED_FROM_CR:   red_from_cr   = value;
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] clamp_channel(int sum);
            if (sum < 0)
                return '0;
            if (sum > CLIP_SUM)
                return yrgb_pkg::CLIP_VALUE;
            return PIX_W'(sum >>> FRAC_W);
        endfunction

        // Returns one RGB888 pixel with red in the lowest byte.
        function logic [23:0] convert_pixel(logic [PIX_W-1:0] luma, int cb, int cr);
            int base;
            int red;
            int green;
            int blue;
            base  = int'(luma_gain) * (int'(luma) - LUMA_BIAS);
            red   = base + int'(red_from_cr) * cr;
            green = base - int'(green_from_cr) * cr - int'(green_from_cb) * cb;
            blue  = base + int'(blue_from_cb) * cb;
            return {clamp_channel(blue), clamp_channel(green), clamp_channel(red)};
        endfunction

        function void note_input(yuyv_word_t w);
            int cb;
            int cr;
            cb = int'(w.chroma_blue) - CHROMA_BIAS;
            cr = int'(w.chroma_red) - CHROMA_BIAS;
            pairs_due.push_back({convert_pixel(w.luma_second, cb, cr),
                                 convert_pixel(w.luma_first, cb, cr)});
        endfunction

        function string channel_name(int i);
            case (i)
                0: return "red_first";
                1: return "green_first";
                2: return "blue_first";
                3: return "red_second";
                4: return "green_second";
                default: return "blue_second";
            endcase
        endfunction

        function void check_result(logic [47:0] got);
            logic [47:0] want;
            if (pairs_due.size() == 0) begin
                $display("%0t: result word %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = pairs_due.pop_front();
            checked++;
            for (int i = 0; i < 6; i++) begin
                if (got[i*8 +: 8] !== want[i*8 +: 8]) begin
                    $display("%0t: %s expected %0d, got %0d", $time, channel_name(i),
                             want[i*8 +: 8], got[i*8 +: 8]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pairs_due.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    rgb_pair_scoreboard sb;
    bit steady = 1'b0;
    int stall_left = 0;
    int settings = 1;

    yuyv_to_rgb_pair_converter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PIX_W'(LUMA_BIAS - 3 + $urandom_range(0, 6));
            3: return PIX_W'(CHROMA_BIAS - 4 + $urandom_range(0, 8));
            4: return PIX_W'($urandom_range(230, 245));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return COEF_W'($urandom_range(0, 63));
            default: return COEF_W'($urandom_range(0, 4095));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver side: random stalls unless a steady stretch is running.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_pair(logic [PIX_W-1:0] y0, logic [PIX_W-1:0] u,
                             logic [PIX_W-1:0] y1, logic [PIX_W-1:0] v);
        yuyv_word_t w;
        int gap;
        w = '{chroma_red: v, luma_second: y1, chroma_blue: u, luma_first: y0};
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = w;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        sb.note_input(w);
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stops sending and waits until every pending pair has come out of the pipeline.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        sb.set_coef(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [COEF_W-1:0] lg, logic [COEF_W-1:0] bcb,
                             logic [COEF_W-1:0] gcr, logic [COEF_W-1:0] gcb,
                             logic [COEF_W-1:0] rcr);
        settle();
        write_coef(yrgb_pkg::REG_LUMA_GAIN, lg);
        write_coef(yrgb_pkg::REG_BLUE_FROM_CB, bcb);
        write_coef(yrgb_pkg::REG_GREEN_FROM_CR, gcr);
        write_coef(yrgb_pkg::REG_GREEN_FROM_CB, gcb);
        write_coef(yrgb_pkg::REG_RED_FROM_CR, rcr);
        settings++;
    endtask

    initial begin
        #TIMEOUT;
        $display("Timed out with %0d pixel pairs still expected", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb = new();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Coefficients straight out of reset: field extremes, black and white levels.
        send_pair(8'd0, 8'd0, 8'd0, 8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0, 8'd255, 8'd255, 8'd0);
        send_pair(8'd255, 8'd0, 8'd0, 8'd255);
        send_pair(8'd16, 8'd128, 8'd235, 8'd128);
        send_pair(8'd235, 8'd16, 8'd16, 8'd240);
        send_pair(8'd81, 8'd90, 8'd145, 8'd54);

        // A gain of 2.0 puts luma 141 exactly on the clip level; one step up clips.
        settle();
        write_coef(yrgb_pkg::REG_LUMA_GAIN, 12'd2048);
        send_pair(8'd141, 8'd128, 8'd140, 8'd128);
        send_pair(8'd142, 8'd128, 8'd141, 8'd128);

        // Tiny chroma gains land red and blue just above the clip level, in the fraction.
        settle();
        write_coef(yrgb_pkg::REG_RED_FROM_CR, 12'd1);
        write_coef(yrgb_pkg::REG_GREEN_FROM_CR, 12'd1);
        write_coef(yrgb_pkg::REG_GREEN_FROM_CB, 12'd0);
        write_coef(yrgb_pkg::REG_BLUE_FROM_CB, 12'd1);
        send_pair(8'd141, 8'd129, 8'd141, 8'd129);

        // Writes beyond the last register must leave the coefficients alone.
        settle();
        for (int i = NUM_COEFS; i < (1 << CFG_IDX_W); i++)
            write_coef(CFG_IDX_W'(i), rand_coef());
        send_pair(8'd141, 8'd129, 8'd141, 8'd129);

        write_all('0, '0, '0, '0, '0);
        send_pair(8'd255, 8'd255, 8'd0, 8'd0);
        send_pair(8'd255, 8'd0, 8'd255, 8'd255);

        write_all('1, '1, '1, '1, '1);
        send_pair(8'd255, 8'd255, 8'd0, 8'd0);
        send_pair(8'd0, 8'd0, 8'd255, 8'd255);
        send_pair(8'd255, 8'd0, 8'd0, 8'd255);
        send_pair(8'd128, 8'd128, 8'd16, 8'd128);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_all(yrgb_pkg::LUMA_GAIN_RST, yrgb_pkg::BLUE_FROM_CB_RST,
                             yrgb_pkg::GREEN_FROM_CR_RST, yrgb_pkg::GREEN_FROM_CB_RST,
                             yrgb_pkg::RED_FROM_CR_RST);
                1: write_all('0, '0, '0, '0, '0);
                2: write_all('1, '1, '1, '1, '1);
                default: write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                                   rand_coef());
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                steady = (n >= 100 && n < 150);
                // Halfway through one phase the sender waits for the pipeline to empty.
                if (p == 3 && n == PHASE_WORDS / 2)
                    settle();
                send_pair(rand_byte(), rand_byte(), rand_byte(), rand_byte());
            end
            steady = 1'b0;
        end

        settle();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);
        $display("Checked %0d pixel pairs under %0d coefficient settings,", sb.checked,
                 settings);
        $display("with clip-level edges, ignored register writes and stalls on both sides.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d pixel pairs never arrived", sb.errors, sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/yrgb_pkg.sv
design/yuyv_to_rgb_pair_converter.sv
verif/yuyv_to_rgb_pair_converter_tb.sv
